// File: hw/rtl/dlf_pkg.sv
// Shared types and constants of the Deming line fit.
`timescale 1ns / 1ps
`default_nettype none
package dlf_pkg;

	localparam int MAX_POINTS_DEF = 1024;
	localparam logic [31:0] RATIO_RESET = 32'h0001_0000;

	// fit status codes
	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_FEW    = 3'd1;
	localparam logic [2:0] ST_SXY0   = 3'd2;
	localparam logic [2:0] ST_SLOPE0 = 3'd3;
	localparam logic [2:0] ST_SIGMA0 = 3'd4;

	// operations of the shared multiply / divide / root unit
	localparam logic [1:0] OP_MUL  = 2'd0;
	localparam logic [1:0] OP_DIV  = 2'd1;
	localparam logic [1:0] OP_SQRT = 2'd2;

	typedef struct packed {
		logic       start;
		logic [1:0] op;
	} mdu_ctl_t;

endpackage
`default_nettype wire

// File: hw/rtl/dlf_ram.sv
// Generic single-port-write RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module dlf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// File: hw/rtl/dlf_mdu.sv
// Shared iterative unit: 128x64 multiply, 128/128 divide and 128-bit square root.
`timescale 1ns / 1ps
`default_nettype none
module dlf_mdu import dlf_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire mdu_ctl_t     ctl,
	input  wire logic [127:0] opa,
	input  wire logic [127:0] opb,
	output logic              done,
	output logic      [127:0] result
);

	logic         busy_q, done_q;
	logic [1:0]   op_q;
	logic [6:0]   cnt_q;
	logic [129:0] acc_q;
	logic [127:0] a_q, b_q;
	logic [63:0]  root_q;

	logic [129:0] lhs, rhs;
	logic         sub;
	logic [130:0] sum;
	logic         ge;

	// one adder / subtractor serves every operation
	always_comb begin
		case (op_q)
			OP_DIV: begin
				lhs = {1'b0, acc_q[127:0], a_q[127]};
				rhs = {2'b00, b_q};
				sub = 1'b1;
			end
			OP_SQRT: begin
				lhs = {acc_q[127:0], a_q[127:126]};
				rhs = {64'd0, root_q, 2'b01};
				sub = 1'b1;
			end
			default: begin
				lhs = acc_q;
				rhs = {2'b00, a_q};
				sub = 1'b0;
			end
		endcase
		sum = {1'b0, lhs} + {1'b0, (sub ? ~rhs : rhs)} + {130'd0, sub};
		ge  = sum[130];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= OP_MUL;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				op_q   <= ctl.op;
				cnt_q  <= (ctl.op == OP_DIV) ? 7'd127 : 7'd63;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			acc_q  <= '0;
			a_q    <= opa;
			b_q    <= opb;
			root_q <= '0;
		end else if (busy_q) begin
			case (op_q)
				OP_DIV: begin
					acc_q <= ge ? {2'b00, sum[127:0]} : {2'b00, lhs[127:0]};
					a_q   <= {a_q[126:0], ge};
				end
				OP_SQRT: begin
					acc_q  <= ge ? sum[129:0] : lhs;
					root_q <= {root_q[62:0], ge};
					a_q    <= {a_q[125:0], 2'b00};
				end
				default: begin
					if (b_q[0]) begin
						acc_q <= {2'b00, sum[127:0]};
					end
					a_q <= {a_q[126:0], 1'b0};
					b_q <= {1'b0, b_q[127:1]};
				end
			endcase
		end
	end

	always_comb begin
		case (op_q)
			OP_DIV:  result = a_q;
			OP_SQRT: result = {64'd0, root_q};
			default: result = acc_q[127:0];
		endcase
	end

	assign done = done_q;

endmodule
`default_nettype wire

// File: hw/rtl/deming_line_fit.sv
// Deming straight-line fit: point store, moment passes and a shared arithmetic unit.
// Load: one point per cycle while idle; the point with last_point starts the fit.
// Fit: a moment pass and a chi-square pass over the stored points, plus normalising and
//   scalar steps; the wide multiplies, divides and square roots run on the shared unit.
// Reset (arst_n low): count, sums, control clear, variance_ratio to 1.0; memory kept.
`timescale 1ns / 1ps
`default_nettype none
module deming_line_fit import dlf_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// point requests
	input  wire logic               point_valid,
	output logic                    point_stall,
	input  wire logic signed [31:0] x_value,
	input  wire logic signed [31:0] y_value,
	input  wire logic        [30:0] y_sigma,
	input  wire logic               last_point,
	// variance ratio register writes
	input  wire logic               ratio_valid,
	output logic                    ratio_ready,
	input  wire logic        [31:0] variance_ratio,
	// result requests
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic signed      [63:0] slope,
	output logic signed      [63:0] y_intercept,
	output logic signed      [63:0] x_intercept,
	output logic             [62:0] chi_square,
	output logic              [9:0] degrees_of_freedom,
	output logic              [2:0] fit_status
);

	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int AW = $clog2(MAX_POINTS);
	localparam int SW = 32 + CW;

	// sequencer states
	localparam logic [5:0] S_LOAD   = 6'd0,  S_START  = 6'd1,  S_P1_RD  = 6'd2;
	localparam logic [5:0] S_P1_UX  = 6'd3,  S_P1_UY  = 6'd4,  S_P1_AXX = 6'd5;
	localparam logic [5:0] S_P1_AYY = 6'd6,  S_P1_AXY = 6'd7,  S_NORM0  = 6'd8;
	localparam logic [5:0] S_NORM   = 6'd9,  S_CHK    = 6'd10, S_A1     = 6'd11;
	localparam logic [5:0] S_A2     = 6'd12, S_A3     = 6'd13, S_A4     = 6'd14;
	localparam logic [5:0] S_A5     = 6'd15, S_A6     = 6'd16, S_A7     = 6'd17;
	localparam logic [5:0] S_A9     = 6'd18, S_A10    = 6'd19, S_B1     = 6'd20;
	localparam logic [5:0] S_B2     = 6'd21, S_B3     = 6'd22, S_C1     = 6'd23;
	localparam logic [5:0] S_C2     = 6'd24, S_D1     = 6'd25, S_D2     = 6'd26;
	localparam logic [5:0] S_D3     = 6'd27, S_D4     = 6'd28, S_E0     = 6'd29;
	localparam logic [5:0] S_E1     = 6'd30, S_E2     = 6'd31, S_E3     = 6'd32;
	localparam logic [5:0] S_E4     = 6'd33, S_E5     = 6'd34, S_E6     = 6'd35;
	localparam logic [5:0] S_E7     = 6'd36, S_E8     = 6'd37, S_E9     = 6'd38;
	localparam logic [5:0] S_E10    = 6'd39, S_OUT    = 6'd40, S_WAIT   = 6'd41;

	// magnitude helpers
	function automatic logic [63:0] mag64(input logic [63:0] v);
		return v[63] ? (~v + 64'd1) : v;
	endfunction

	function automatic logic [127:0] mag128(input logic [127:0] v);
		return v[127] ? (~v + 128'd1) : v;
	endfunction

	// apply the sign to a quotient magnitude and saturate to 64 bits
	function automatic logic [63:0] qsat(input logic [127:0] q, input logic neg);
		logic big;
		big = |q[127:63];
		if (!neg) begin
			return big ? 64'h7FFF_FFFF_FFFF_FFFF : q[63:0];
		end
		return big ? 64'h8000_0000_0000_0000 : (~q[63:0] + 64'd1);
	endfunction

	logic [5:0]  state_q, ret_q;
	logic [31:0] ratio_q;
	logic [CW-1:0] cnt_q, idx_q;
	logic signed [SW-1:0] sumx_q, sumy_q;

	logic [127:0] sxx_q, syy_q, sxy_q, t1_q, res_q;
	logic signed [127:0] work_q, chiacc_q;
	logic signed [63:0]  ux_q, uy_q, a_q, a1_q, a2_q, xi_q;
	logic [60:0]  tmp_q;
	logic [63:0]  w_q;
	logic [62:0]  chi_q;
	logic [2:0]   status_q;
	logic         sneg_q, sig0_q, negf_q, sat_q;

	// shared unit request
	mdu_ctl_t     mop_ctl_q, mop_ctl_d;
	logic [127:0] mop_a_q, mop_b_q;
	logic         mdu_done;
	logic [127:0] mdu_result;

	// result holding register
	logic         result_valid_q;
	logic [63:0]  slope_q, yint_q, xint_q;
	logic [62:0]  chi_out_q;
	logic [9:0]   dof_q;
	logic [2:0]   status_out_q;

	// point memory: {x, y, sigma}
	logic          ram_we;
	logic [94:0]   ram_rdata;
	logic signed [31:0] rd_x, rd_y;
	logic [30:0]   rd_s;
	logic          accept;

	assign accept  = point_valid && !point_stall;
	assign ram_we  = accept && (cnt_q < CW'(MAX_POINTS));
	assign rd_x    = ram_rdata[94:63];
	assign rd_y    = ram_rdata[62:31];
	assign rd_s    = ram_rdata[30:0];

	dlf_ram #(
		.WIDTH(95),
		.DEPTH(MAX_POINTS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(cnt_q[AW-1:0]),
		.wdata({x_value, y_value, y_sigma}),
		.raddr(idx_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	dlf_mdu u_mdu (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (mop_ctl_q),
		.opa   (mop_a_q),
		.opb   (mop_b_q),
		.done  (mdu_done),
		.result(mdu_result)
	);

	// narrow multipliers: n * coordinate, ratio * moment, and Sxy squared
	logic signed [31:0]   nsel;
	logic signed [CW+32:0] nprod;
	logic [28:0]  vsel;
	logic [60:0]  vmul;
	logic [57:0]  sm2;
	logic [63:0]  apr;
	logic signed [127:0] sy_sh, y_sh, a2_sh;
	logic         last_idx;
	logic [31:0]  dof_w;

	assign nsel     = (state_q == S_P1_UX) ? rd_x : rd_y;
	assign nprod    = $signed({1'b0, cnt_q}) * nsel;
	assign vsel     = (state_q == S_A1) ? sxx_q[28:0] : sxy_q[28:0];
	assign vmul     = ratio_q * vsel;
	assign sm2      = sxy_q[28:0] * sxy_q[28:0];
	assign apr      = a_q + res_q[63:0];
	assign sy_sh    = 128'(sumy_q) <<< 32;
	assign y_sh     = 128'(rd_y) <<< 32;
	assign a2_sh    = 128'(a2_q) <<< 16;
	assign last_idx = (CW'(idx_q + 1'b1) == cnt_q);
	assign dof_w    = 32'(cnt_q) - 32'd2;

	// issue one operation to the shared unit from the states that need it
	always_comb begin
		mop_ctl_d = '0;
		case (state_q)
			S_P1_UY, S_P1_AXX, S_P1_AYY, S_A3, S_A4, S_A10, S_E2, S_E7: begin
				mop_ctl_d = '{start: 1'b1, op: OP_MUL};
			end
			S_A6: mop_ctl_d = '{start: 1'b1, op: OP_SQRT};
			S_A7, S_B2, S_E5: begin
				mop_ctl_d = '{start: 1'b1, op: OP_DIV};
			end
			S_C1: begin
				if (a1_q != '0) begin
					mop_ctl_d = '{start: 1'b1, op: OP_DIV};
				end
			end
			S_D1: begin
				if (!sig0_q) begin
					mop_ctl_d = '{start: 1'b1, op: OP_MUL};
				end
			end
			S_D3: begin
				if (t1_q != '0) begin
					mop_ctl_d = '{start: 1'b1, op: OP_DIV};
				end
			end
			S_E6: begin
				if (!(|res_q[127:63])) begin
					mop_ctl_d = '{start: 1'b1, op: OP_MUL};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_LOAD;
			ret_q          <= S_LOAD;
			ratio_q        <= RATIO_RESET;
			cnt_q          <= '0;
			sumx_q         <= '0;
			sumy_q         <= '0;
			mop_ctl_q      <= '0;
			result_valid_q <= 1'b0;
		end else begin
			mop_ctl_q <= mop_ctl_d;
			if (ratio_valid && ratio_ready) begin
				ratio_q <= variance_ratio;
			end
			// drop the held result once taken, unless a new one replaces it
			if (result_valid_q && !result_stall && state_q != S_OUT) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (ram_we) begin
							cnt_q  <= cnt_q + 1'b1;
							sumx_q <= sumx_q + SW'(x_value);
							sumy_q <= sumy_q + SW'(y_value);
						end
						if (last_point) begin
							state_q <= S_START;
						end
					end
				end
				S_START: begin
					state_q <= (cnt_q < CW'(2)) ? S_OUT : S_P1_RD;
				end
				S_P1_RD:  state_q <= S_P1_UX;
				S_P1_UX:  state_q <= S_P1_UY;
				S_P1_UY: begin
					ret_q     <= S_P1_AXX;
					state_q   <= S_WAIT;
				end
				S_P1_AXX: begin
					ret_q     <= S_P1_AYY;
					state_q   <= S_WAIT;
				end
				S_P1_AYY: begin
					ret_q     <= S_P1_AXY;
					state_q   <= S_WAIT;
				end
				S_P1_AXY: state_q <= last_idx ? S_NORM0 : S_P1_RD;
				S_NORM0:  state_q <= S_NORM;
				S_NORM: begin
					if (~|((sxx_q | syy_q | sxy_q) >> 29)) begin
						state_q <= S_CHK;
					end
				end
				S_CHK:  state_q <= (sxy_q == '0) ? S_OUT : S_A1;
				S_A1:   state_q <= S_A2;
				S_A2:   state_q <= S_A3;
				S_A3, S_A4, S_A6, S_A7, S_A10, S_B2, S_D2: begin
					// these states, all but S_D2, issue one operation to the shared unit
					if (state_q == S_D2) begin
						state_q <= S_D3;
					end else begin
						state_q <= S_WAIT;
						case (state_q)
							S_A3:    ret_q <= S_A4;
							S_A4:    ret_q <= S_A5;
							S_A6:    ret_q <= S_A7;
							S_A7:    ret_q <= S_A9;
							S_A10:   ret_q <= S_B1;
							default: ret_q <= S_B3;
						endcase
					end
				end
				S_A5:   state_q <= S_A6;
				S_A9:   state_q <= S_A10;
				S_B1:   state_q <= S_B2;
				S_B3:   state_q <= S_C1;
				S_C1: begin
					if (a1_q == '0) begin
						state_q <= S_D1;
					end else begin
						ret_q     <= S_C2;
						state_q   <= S_WAIT;
					end
				end
				S_C2:   state_q <= S_D1;
				S_D1: begin
					if (sig0_q) begin
						state_q <= S_OUT;
					end else begin
						ret_q     <= S_D2;
						state_q   <= S_WAIT;
					end
				end
				S_D3: begin
					if (t1_q == '0) begin
						state_q <= S_E0;
					end else begin
						ret_q     <= S_D4;
						state_q   <= S_WAIT;
					end
				end
				S_D4:   state_q <= S_E0;
				S_E0:   state_q <= S_E1;
				S_E1:   state_q <= S_E2;
				S_E2: begin
					ret_q     <= S_E3;
					state_q   <= S_WAIT;
				end
				S_E3:   state_q <= S_E4;
				S_E4:   state_q <= S_E5;
				S_E5: begin
					ret_q     <= S_E6;
					state_q   <= S_WAIT;
				end
				S_E6: begin
					if (|res_q[127:63]) begin
						state_q <= S_E9;
					end else begin
						ret_q     <= S_E7;
						state_q   <= S_WAIT;
					end
				end
				S_E7: begin
					ret_q     <= S_E8;
					state_q   <= S_WAIT;
				end
				S_E8:   state_q <= S_E9;
				S_E9:   state_q <= last_idx ? S_E10 : S_E1;
				S_E10:  state_q <= S_OUT;
				S_OUT: begin
					// hold until the result register is free, then clear the set
					if (!result_valid_q || !result_stall) begin
						result_valid_q <= 1'b1;
						cnt_q          <= '0;
						sumx_q         <= '0;
						sumy_q         <= '0;
						state_q        <= S_LOAD;
					end
				end
				S_WAIT: begin
					if (mdu_done) begin
						state_q <= ret_q;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_START: begin
				status_q <= (cnt_q < CW'(2)) ? ST_FEW : ST_OK;
				a1_q     <= '0;
				a2_q     <= '0;
				xi_q     <= '0;
				chi_q    <= '0;
				sxx_q    <= '0;
				syy_q    <= '0;
				sxy_q    <= '0;
				sig0_q   <= 1'b0;
				idx_q    <= '0;
			end
			S_P1_UX: begin
				ux_q <= 64'(nprod) - 64'(sumx_q);
			end
			S_P1_UY: begin
				uy_q    <= 64'(nprod) - 64'(sumy_q);
				sig0_q  <= sig0_q | (rd_s == '0);
				mop_a_q <= {64'd0, mag64(ux_q)};
				mop_b_q <= {64'd0, mag64(ux_q)};
			end
			S_P1_AXX: begin
				sxx_q   <= sxx_q + res_q;
				mop_a_q <= {64'd0, mag64(uy_q)};
				mop_b_q <= {64'd0, mag64(uy_q)};
			end
			S_P1_AYY: begin
				syy_q   <= syy_q + res_q;
				mop_a_q <= {64'd0, mag64(ux_q)};
				mop_b_q <= {64'd0, mag64(uy_q)};
			end
			S_P1_AXY: begin
				sxy_q <= (ux_q[63] ^ uy_q[63]) ? (sxy_q - res_q) : (sxy_q + res_q);
				idx_q <= CW'(idx_q + 1'b1);
			end
			S_NORM0: begin
				sneg_q <= sxy_q[127];
				sxy_q  <= mag128(sxy_q);
			end
			S_NORM: begin
				if (|((sxx_q | syy_q | sxy_q) >> 29)) begin
					sxx_q <= sxx_q >> 1;
					syy_q <= syy_q >> 1;
					sxy_q <= sxy_q >> 1;
				end
			end
			S_CHK: begin
				if (sxy_q == '0) begin
					status_q <= ST_SXY0;
				end
			end
			S_A1: tmp_q <= vmul;
			S_A2: a_q   <= $signed({19'd0, syy_q[28:0], 16'd0}) - $signed({3'd0, tmp_q});
			S_A3: begin
				mop_a_q <= {64'd0, mag64(a_q)};
				mop_b_q <= {64'd0, mag64(a_q)};
			end
			S_A4: begin
				t1_q    <= res_q;
				mop_a_q <= {70'd0, sm2};
				mop_b_q <= {78'd0, ratio_q, 18'd0};
			end
			S_A5: t1_q <= t1_q + res_q;
			S_A6: mop_a_q <= t1_q;
			S_A7: begin
				// A >= 0: (A+R)*2^15 / Sxy, otherwise 2^33*V*Sxy / (R-A)
				if (!a_q[63]) begin
					mop_a_q <= {49'd0, apr, 15'd0};
					mop_b_q <= {99'd0, sxy_q[28:0]};
				end else begin
					mop_a_q <= {34'd0, vmul, 33'd0};
					mop_b_q <= {64'd0, res_q[63:0]} + {64'd0, mag64(a_q)};
				end
			end
			S_A9: a1_q <= qsat(res_q, sneg_q);
			S_A10: begin
				negf_q  <= a1_q[63] ^ sumx_q[SW-1];
				mop_a_q <= {64'd0, mag64(a1_q)};
				mop_b_q <= {64'd0, mag64(64'(sumx_q))};
			end
			S_B1: work_q <= negf_q ? (sy_sh + res_q) : (sy_sh - res_q);
			S_B2: begin
				negf_q  <= work_q[127];
				mop_a_q <= mag128(work_q);
				mop_b_q <= 128'(cnt_q) << 16;
			end
			S_B3: a2_q <= qsat(res_q, negf_q);
			S_C1: begin
				if (a1_q == '0) begin
					status_q <= ST_SLOPE0;
				end
				negf_q  <= a1_q[63] ? a2_q[63] : (!a2_q[63] && a2_q != '0);
				mop_a_q <= {32'd0, mag64(a2_q), 32'd0};
				mop_b_q <= {64'd0, mag64(a1_q)};
			end
			S_C2: xi_q <= qsat(res_q, negf_q);
			S_D1: begin
				if (sig0_q && status_q == ST_OK) begin
					status_q <= ST_SIGMA0;
				end
				mop_a_q <= {64'd0, mag64(a1_q)};
				mop_b_q <= {64'd0, mag64(a1_q)};
			end
			S_D2: t1_q <= res_q + {48'd0, ratio_q, 48'd0};
			S_D3: begin
				w_q     <= '0;
				mop_a_q <= {16'd0, ratio_q, 80'd0};
				mop_b_q <= t1_q;
			end
			S_D4: w_q <= res_q[63:0];
			S_E0: begin
				chiacc_q <= '0;
				sat_q    <= 1'b0;
				idx_q    <= '0;
			end
			S_E2: begin
				negf_q  <= a1_q[63] ^ rd_x[31];
				mop_a_q <= {64'd0, mag64(a1_q)};
				mop_b_q <= {64'd0, mag64(64'(rd_x))};
			end
			S_E3: work_q <= negf_q ? (y_sh + res_q) : (y_sh - res_q);
			S_E4: work_q <= work_q - a2_sh;
			S_E5: begin
				mop_a_q <= mag128(work_q);
				mop_b_q <= {97'd0, rd_s};
			end
			S_E6: begin
				if (|res_q[127:63]) begin
					sat_q <= 1'b1;
				end
				mop_a_q <= {64'd0, res_q[63:0]};
				mop_b_q <= {64'd0, res_q[63:0]};
			end
			S_E7: begin
				mop_a_q <= {32'd0, res_q[127:32]};
				mop_b_q <= {64'd0, w_q};
			end
			S_E8: chiacc_q <= chiacc_q + {32'd0, res_q[127:32]};
			S_E9: idx_q <= CW'(idx_q + 1'b1);
			S_E10: begin
				chi_q <= (sat_q || (|chiacc_q[127:63])) ? {63{1'b1}} : chiacc_q[62:0];
			end
			S_OUT: begin
				if (!result_valid_q || !result_stall) begin
					slope_q      <= a1_q;
					yint_q       <= a2_q;
					xint_q       <= xi_q;
					chi_out_q    <= chi_q;
					status_out_q <= status_q;
					if (cnt_q < CW'(2)) begin
						dof_q <= '0;
					end else begin
						dof_q <= (dof_w > 32'd1023) ? 10'd1023 : dof_w[9:0];
					end
				end
			end
			S_WAIT: begin
				if (mdu_done) begin
					res_q <= mdu_result;
				end
			end
			default: ;
		endcase
	end

	assign point_stall        = (state_q != S_LOAD);
	assign ratio_ready        = (state_q == S_LOAD);
	assign result_valid       = result_valid_q;
	assign slope              = slope_q;
	assign y_intercept        = yint_q;
	assign x_intercept        = xint_q;
	assign chi_square         = chi_out_q;
	assign degrees_of_freedom = dof_q;
	assign fit_status         = status_out_q;

	// the shared unit only finishes while the sequencer waits on it
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mdu_done |-> state_q == S_WAIT)
		else $error("shared unit finished outside its wait state");

	// a new result only appears from the hand-over state
	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q) == S_OUT)
		else $error("result raised outside hand-over");

	// the point count never passes the store depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_POINTS))
		else $error("point count beyond store depth");

	// a set of fewer than two points reports zero slope, chi-square and degrees of freedom
	a_few_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && fit_status == ST_FEW) |->
			(slope == '0 && chi_square == '0 && degrees_of_freedom == '0))
		else $error("short set reported non-zero fields");

endmodule
`default_nettype wire

// File: tb/deming_line_fit_test.sv
// Self-checking testbench for deming_line_fit: randomised point sets checked against a fit predictor.
`timescale 1ns / 1ps
module deming_line_fit_test;
	import dlf_pkg::*;

	localparam int STORE_DEPTH = MAX_POINTS_DEF;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int SETTLE_CYCLES = 40;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic        [30:0] sigma;
		logic               last;
	} point_t;

	typedef struct {
		logic signed [63:0] slope;
		logic signed [63:0] y_icpt;
		logic signed [63:0] x_icpt;
		logic        [62:0] chi;
		logic         [9:0] dof;
		logic         [2:0] status;
	} fit_t;

	logic clk;
	logic arst_n;
	logic point_valid;
	logic point_stall;
	logic signed [31:0] x_value;
	logic signed [31:0] y_value;
	logic [30:0] y_sigma;
	logic last_point;
	logic ratio_valid;
	logic ratio_ready;
	logic [31:0] variance_ratio;
	logic result_valid;
	logic result_stall;
	logic signed [63:0] slope;
	logic signed [63:0] y_intercept;
	logic signed [63:0] x_intercept;
	logic [62:0] chi_square;
	logic [9:0] degrees_of_freedom;
	logic [2:0] fit_status;

	deming_line_fit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.point_valid(point_valid),
		.point_stall(point_stall),
		.x_value(x_value),
		.y_value(y_value),
		.y_sigma(y_sigma),
		.last_point(last_point),
		.ratio_valid(ratio_valid),
		.ratio_ready(ratio_ready),
		.variance_ratio(variance_ratio),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.slope(slope),
		.y_intercept(y_intercept),
		.x_intercept(x_intercept),
		.chi_square(chi_square),
		.degrees_of_freedom(degrees_of_freedom),
		.fit_status(fit_status)
	);

	// Shadow of the block's state, advanced on every accepted request
	logic signed [31:0] shadow_x [STORE_DEPTH];
	logic signed [31:0] shadow_y [STORE_DEPTH];
	logic        [30:0] shadow_sigma [STORE_DEPTH];
	int unsigned        shadow_count;
	longint             shadow_sum_x;
	longint             shadow_sum_y;
	logic        [31:0] shadow_ratio;

	point_t pending_points [$];
	fit_t   expected_fits [$];
	int     error_count;
	int     cycle_count;
	int     send_gap;
	int     stall_left;
	bit     point_taken;
	bit     calm;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Floor square root, one bit per trial from the top
	function automatic logic [63:0] floor_root(input logic [127:0] v);
		logic [63:0] r;
		logic [63:0] t;
		r = '0;
		for (int b = 62; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (v >= {64'd0, t} * {64'd0, t})
				r = t;
		end
		return r;
	endfunction

	// Truncating signed quotient, saturated to 64 bits
	function automatic logic signed [63:0] clamp_quotient(input logic signed [127:0] num,
			input logic [127:0] den);
		logic [127:0] mag;
		logic [127:0] q;
		mag = num[127] ? -num : num;
		q = mag / den;
		if (!num[127])
			return (q > 128'h7FFF_FFFF_FFFF_FFFF) ? 64'sh7FFF_FFFF_FFFF_FFFF : q[63:0];
		if (q >= 128'h8000_0000_0000_0000)
			return 64'sh8000_0000_0000_0000;
		return -q[63:0];
	endfunction

	// Deming fit over the shadow store, exact integer form
	function automatic fit_t deming_fit();
		fit_t f;
		logic signed [127:0] nn, sx, sy, ux, uy, sxx, syy, sxy, av, vv, num, r, a1w, a2w;
		logic [127:0] mxx, myy, mxy, m, den, wden, t, p, acc;
		logic [63:0] root, w;
		logic [127:0] a1mag;
		bit sneg, sig0, sat;
		f = '{default: '0};
		nn = shadow_count;
		sx = shadow_sum_x;
		sy = shadow_sum_y;
		vv = {96'd0, shadow_ratio};
		sxx = 0;
		syy = 0;
		sxy = 0;
		sig0 = 0;
		f.dof = (shadow_count >= 2) ? ((shadow_count - 2 > 1023) ? 10'd1023 : 10'(shadow_count - 2))
			: 10'd0;
		if (shadow_count < 2) begin
			f.status = ST_FEW;
			return f;
		end
		for (int i = 0; i < shadow_count; i++) begin
			ux = nn * 128'(signed'(shadow_x[i])) - sx;
			uy = nn * 128'(signed'(shadow_y[i])) - sy;
			sxx += ux * ux;
			syy += uy * uy;
			sxy += ux * uy;
			if (shadow_sigma[i] == 0)
				sig0 = 1;
		end
		sneg = sxy[127];
		mxx = sxx;
		myy = syy;
		mxy = sneg ? -sxy : sxy;
		m = mxx;
		if (myy >= m) m = myy;
		if (mxy >= m) m = mxy;
		// normalise all three moments by one common shift
		while (m >= (128'd1 << 29)) begin
			m >>= 1;
			mxx >>= 1;
			myy >>= 1;
			mxy >>= 1;
		end
		if (mxy == 0) begin
			f.status = ST_SXY0;
			return f;
		end
		av = 65536 * $signed(myy) - vv * $signed(mxx);
		root = floor_root(128'(av * av) + ((vv << 18) * (mxy * mxy)));
		if (!av[127]) begin
			num = (av + $signed({64'd0, root})) <<< 15;
			den = mxy;
		end else begin
			num = (vv * $signed(mxy)) <<< 33;
			den = {64'd0, root} + 128'(-av);
		end
		if (sneg)
			num = -num;
		f.slope = clamp_quotient(num, den);
		a1w = f.slope;
		f.y_icpt = clamp_quotient(sy * (128'sd1 <<< 32) - a1w * sx, 128'(shadow_count) << 16);
		a2w = f.y_icpt;
		a1mag = a1w[127] ? -a1w : a1w;
		if (f.slope == 0) begin
			f.status = ST_SLOPE0;
		end else begin
			num = a2w * (128'sd1 <<< 32);
			if (f.slope > 0)
				num = -num;
			f.x_icpt = clamp_quotient(num, a1mag);
		end
		if (sig0) begin
			if (f.status == ST_OK)
				f.status = ST_SIGMA0;
			return f;
		end
		// weight delta / (slope^2 + delta) with 32 fraction bits
		wden = a1mag * a1mag + ({96'd0, shadow_ratio} << 48);
		w = (wden == 0) ? 64'd0 : 64'(({96'd0, shadow_ratio} << 80) / wden);
		acc = 0;
		sat = 0;
		for (int i = 0; i < shadow_count; i++) begin
			r = 128'(signed'(shadow_y[i])) * (128'sd1 <<< 32) - a1w * 128'(signed'(shadow_x[i]))
				- a2w * 65536;
			t = (r[127] ? -r : r) / {97'd0, shadow_sigma[i]};
			if (t >= (128'd1 << 63)) begin
				sat = 1;
				continue;
			end
			p = (t * t) >> 32;
			p = p * {64'd0, w};
			acc += p >> 32;
		end
		f.chi = (sat || acc > 128'h7FFF_FFFF_FFFF_FFFF) ? 63'h7FFF_FFFF_FFFF_FFFF : acc[62:0];
		return f;
	endfunction

	// Drive point requests at the falling edge; idle in random bursts
	always @(negedge clk) begin
		point_t p;
		if (arst_n && (!point_valid || point_taken)) begin
			if (send_gap > 0) begin
				send_gap--;
				point_valid <= 1'b0;
			end else if (pending_points.size() != 0) begin
				p = pending_points.pop_front();
				x_value <= p.x;
				y_value <= p.y;
				y_sigma <= p.sigma;
				last_point <= p.last;
				point_valid <= 1'b1;
				if (!calm && $urandom_range(0, 5) == 0)
					send_gap = $urandom_range(1, 5);
			end else begin
				point_valid <= 1'b0;
			end
		end
		point_taken = 0;
		// result back-pressure
		if (stall_left > 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 4);
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	// Sample at the rising edge: update the shadow state and check results
	always @(posedge clk) begin
		fit_t e;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** deming_line_fit: FAILED **");
			$finish;
		end
		if (arst_n && ratio_valid && ratio_ready)
			shadow_ratio = variance_ratio;
		if (arst_n && point_valid && !point_stall) begin
			point_taken = 1;
			// drop points once the store is full, the final one included
			if (shadow_count < STORE_DEPTH) begin
				shadow_x[shadow_count] = x_value;
				shadow_y[shadow_count] = y_value;
				shadow_sigma[shadow_count] = y_sigma;
				shadow_count++;
				shadow_sum_x += longint'(x_value);
				shadow_sum_y += longint'(y_value);
			end
			if (last_point) begin
				expected_fits.push_back(deming_fit());
				shadow_count = 0;
				shadow_sum_x = 0;
				shadow_sum_y = 0;
			end
		end
		if (arst_n && result_valid && !result_stall) begin
			if (expected_fits.size() == 0) begin
				$error("unexpected result: slope %0d status %0d", slope, fit_status);
				error_count++;
			end else begin
				e = expected_fits.pop_front();
				if (slope !== e.slope) begin
					$error("slope: expected %0d, got %0d", e.slope, slope);
					error_count++;
				end
				if (y_intercept !== e.y_icpt) begin
					$error("y_intercept: expected %0d, got %0d", e.y_icpt, y_intercept);
					error_count++;
				end
				if (x_intercept !== e.x_icpt) begin
					$error("x_intercept: expected %0d, got %0d", e.x_icpt, x_intercept);
					error_count++;
				end
				if (chi_square !== e.chi) begin
					$error("chi_square: expected %0d, got %0d", e.chi, chi_square);
					error_count++;
				end
				if (degrees_of_freedom !== e.dof) begin
					$error("degrees_of_freedom: expected %0d, got %0d", e.dof,
						degrees_of_freedom);
					error_count++;
				end
				if (fit_status !== e.status) begin
					$error("fit_status: expected %0d, got %0d", e.status, fit_status);
					error_count++;
				end
			end
		end
	end

	task automatic add_point(input logic signed [31:0] x, input logic signed [31:0] y,
			input logic [30:0] s, input logic last);
		point_t p;
		p.x = x;
		p.y = y;
		p.sigma = s;
		p.last = last;
		pending_points.push_back(p);
	endtask

	// Hold until every request is taken and every fit has come back, then let the block settle
	task automatic drain();
		while (pending_points.size() != 0 || point_valid || expected_fits.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_ratio(input logic [31:0] v);
		drain();
		variance_ratio <= v;
		ratio_valid <= 1'b1;
		@(posedge clk);
		while (!ratio_ready)
			@(posedge clk);
		@(negedge clk);
		ratio_valid <= 1'b0;
	endtask

	function automatic logic [30:0] rand_sigma();
		case ($urandom_range(0, 39))
			0: return '0;
			1: return 31'd1;
			2, 3: return 31'($urandom);
			default: return 31'($urandom_range(1, 32'h7FFF_FFFF) >> $urandom_range(4, 20)) | 31'd1;
		endcase
	endfunction

	// One data set: mostly noisy points about a random line, sometimes plain noise
	task automatic add_set(input int size);
		int e, ks, kd;
		logic signed [31:0] x, y, b;
		bit noisy;
		noisy = ($urandom_range(0, 4) == 0);
		e = $urandom_range(0, 16);
		ks = $urandom_range(0, 12);
		kd = $urandom_range(0, 1);
		b = $signed($urandom) >>> $urandom_range(0, 20);
		for (int i = 0; i < size; i++) begin
			x = $signed($urandom) >>> e;
			if (noisy)
				y = $signed($urandom);
			else
				y = (kd ? (x >>> ks) : (x <<< ($urandom_range(0, 1) ? 0 : 1))) + b
					+ ($signed($urandom) >>> $urandom_range(6, 31));
			add_point(x, y, rand_sigma(), i == size - 1);
		end
	endtask

	task automatic random_sets(input int items);
		int done, n;
		done = 0;
		while (done < items) begin
			case ($urandom_range(0, 19))
				0: n = 1;
				1, 2: n = $urandom_range(9, 30);
				default: n = $urandom_range(2, 8);
			endcase
			add_set(n);
			done += n;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		point_valid = 1'b0;
		x_value = '0;
		y_value = '0;
		y_sigma = '0;
		last_point = 1'b0;
		ratio_valid = 1'b0;
		variance_ratio = '0;
		result_stall = 1'b0;
		shadow_count = 0;
		shadow_sum_x = 0;
		shadow_sum_y = 0;
		shadow_ratio = RATIO_RESET;
		error_count = 0;
		cycle_count = 0;
		send_gap = 0;
		stall_left = 0;
		point_taken = 0;
		calm = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// lone point: too few points
		add_point(32'sd65536, 32'sd65536, 31'd65536, 1'b1);
		// two points at the extremes of every field
		add_point(32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
		add_point(32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF, 1'b1);
		// identical x: no covariance
		add_point(32'sd1000, 32'sd5, 31'd10, 1'b0);
		add_point(32'sd1000, 32'sd900, 31'd10, 1'b1);
		// wide x, one-count rise in y: slope may truncate to zero
		add_point(32'sh8000_0000, 32'sd0, 31'd1, 1'b0);
		add_point(32'sh7FFF_FFFF, 32'sd1, 31'd1, 1'b0);
		add_point(32'sd0, 32'sd0, 31'd1, 1'b1);
		// a zero uncertainty among good points
		add_point(32'sd65536, 32'sd131072, 31'd65536, 1'b0);
		add_point(32'sd131072, 32'sd262144, 31'd0, 1'b0);
		add_point(32'sd196608, 32'sd400000, 31'd65536, 1'b1);
		// scattered points with a tiny uncertainty: residual term saturates
		add_point(32'sh4000_0000, 32'sh8000_0000, 31'd1, 1'b0);
		add_point(32'shC000_0000, 32'sh7000_0000, 31'd1, 1'b0);
		add_point(32'sh1000_0000, 32'sh9000_0000, 31'd1, 1'b1);
		// clean line, unit weights
		add_point(32'sd0, 32'sd65536, 31'd65536, 1'b0);
		add_point(32'sd65536, 32'sd196608, 31'd65536, 1'b0);
		add_point(32'sd131072, 32'sd327680, 31'd65536, 1'b1);

		// random sets under several ratios, the extremes and zero among them
		write_ratio(32'd1);
		random_sets(35);
		write_ratio(32'hFFFF_FFFF);
		random_sets(35);
		write_ratio(32'd0);
		add_point(32'sd10, 32'sd7, 31'd3, 1'b0);
		add_point(32'sd20, 32'sd7, 31'd3, 1'b1);
		random_sets(20);
		write_ratio(32'h0003_0000);
		random_sets(35);
		write_ratio($urandom);
		random_sets(35);

		// overfull set: points past the store depth are dropped, the final one too
		write_ratio(RATIO_RESET);
		add_set(STORE_DEPTH + 6);

		// closing stretch with no idling on either side
		drain();
		calm = 1;
		random_sets(40);

		drain();
		if (error_count == 0) begin
			$display("** deming_line_fit: PASSED **");
		end else begin
			$display("** deming_line_fit: FAILED **");
		end
		$finish;
	end

endmodule
